// ===== hw/rtl/uqp_pkg.sv =====
// Shared types and constants for the URI query parameter parser.
// No dependencies; imported by uqp_core and uri_query_param_parser.
`default_nettype none

package uqp_pkg;

    localparam int CHAR_BITS    = 8;
    localparam int SIZE_BITS    = 16;
    localparam int STATUS_BITS  = 2;
    localparam int CROP_BITS    = 4;
    localparam int QUAL_BITS    = 7;
    localparam int QACC_BITS    = 8;
    localparam int NAME_OUT_BITS = 12;
    localparam int CFG_IDX_BITS = 1;
    localparam int M_TDATA_BITS = 64;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_HEIGHT = 1'd1;
    localparam logic [SIZE_BITS-1:0]    MAX_SIZE_RESET = 16'd4096;

    // parse phase
    localparam logic [1:0] PH_NAME   = 2'd0;
    localparam logic [1:0] PH_PARAMS = 2'd1;
    localparam logic [1:0] PH_ERROR  = 2'd2;

    // selected key
    localparam logic [2:0] KEY_NONE = 3'd0;
    localparam logic [2:0] KEY_W    = 3'd1;
    localparam logic [2:0] KEY_H    = 3'd2;
    localparam logic [2:0] KEY_C    = 3'd3;
    localparam logic [2:0] KEY_Q    = 3'd4;

    // result status
    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NO_QUERY  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_SYNTAX    = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_SIZE_OOR  = 2'd3;

    // characters
    localparam logic [CHAR_BITS-1:0] CH_QMARK = 8'h3F;
    localparam logic [CHAR_BITS-1:0] CH_W     = 8'h77;
    localparam logic [CHAR_BITS-1:0] CH_H     = 8'h68;
    localparam logic [CHAR_BITS-1:0] CH_C     = 8'h63;
    localparam logic [CHAR_BITS-1:0] CH_Q     = 8'h71;
    localparam logic [CHAR_BITS-1:0] CH_AMP   = 8'h26;
    localparam logic [CHAR_BITS-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;

    localparam logic [QUAL_BITS-1:0] DEFAULT_QUALITY = 7'd100;
    localparam logic [CROP_BITS-1:0] DEFAULT_CROP    = 4'd1;

    typedef struct packed {
        logic [NAME_OUT_BITS-1:0] name_length;
        logic [QUAL_BITS-1:0]     quality;
        logic [CROP_BITS-1:0]     crop;
        logic [SIZE_BITS-1:0]     height;
        logic [SIZE_BITS-1:0]     width;
        logic [STATUS_BITS-1:0]   status;
    } uqp_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/uqp_core.sv =====
// Parse state and per-byte next-state / result logic of the URI parser.
// Depends on uqp_pkg.
`default_nettype none

module uqp_core #(
    parameter int ACC_BITS      = 20,
    parameter int NAME_LEN_BITS = 12
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              proc_en,
    input  wire logic [uqp_pkg::CHAR_BITS-1:0]     char_byte,
    input  wire logic                              last_byte,
    input  wire logic [uqp_pkg::SIZE_BITS-1:0]     max_width,
    input  wire logic [uqp_pkg::SIZE_BITS-1:0]     max_height,
    output uqp_pkg::uqp_result_t                   result
);
    import uqp_pkg::*;

    localparam logic [ACC_BITS-1:0]      ACC_CAP  = {ACC_BITS{1'b1}};
    localparam logic [NAME_LEN_BITS-1:0] NAME_CAP = {NAME_LEN_BITS{1'b1}};
    localparam logic [QACC_BITS-1:0]     QACC_CAP = {QACC_BITS{1'b1}};

    logic [1:0]               phase_reg, phase_next;
    logic [2:0]               key_reg, key_next;
    logic [ACC_BITS-1:0]      wacc_reg, wacc_next;
    logic [ACC_BITS-1:0]      hacc_reg, hacc_next;
    logic [CROP_BITS-1:0]     crop_reg, crop_next;
    logic [QACC_BITS-1:0]     qacc_reg, qacc_next;
    logic [NAME_LEN_BITS-1:0] name_reg, name_next;

    logic [CROP_BITS-1:0] digit;
    logic [ACC_BITS+3:0]  w_mul, h_mul;
    logic [QACC_BITS+3:0] q_mul;
    logic                 is_digit;

    assign digit    = char_byte[CROP_BITS-1:0];
    assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    assign w_mul = {wacc_reg, 3'b000} + {2'b00, wacc_reg, 1'b0}
                 + {{ACC_BITS{1'b0}}, digit};
    assign h_mul = {hacc_reg, 3'b000} + {2'b00, hacc_reg, 1'b0}
                 + {{ACC_BITS{1'b0}}, digit};
    assign q_mul = {qacc_reg, 3'b000} + {2'b00, qacc_reg, 1'b0}
                 + {{QACC_BITS{1'b0}}, digit};

    always_comb begin
        phase_next = phase_reg;
        key_next   = key_reg;
        wacc_next  = wacc_reg;
        hacc_next  = hacc_reg;
        crop_next  = crop_reg;
        qacc_next  = qacc_reg;
        name_next  = name_reg;
        if (phase_reg == PH_NAME) begin
            if (char_byte == CH_QMARK) begin
                phase_next = last_byte ? PH_ERROR : PH_PARAMS;
            end else if (name_reg != NAME_CAP) begin
                name_next = name_reg + 1'b1;
            end
        end else if (phase_reg == PH_PARAMS) begin
            if (char_byte == CH_W) begin
                key_next = KEY_W;
            end else if (char_byte == CH_H) begin
                key_next = KEY_H;
            end else if (char_byte == CH_C) begin
                key_next = KEY_C;
            end else if (char_byte == CH_Q) begin
                key_next = KEY_Q;
            end else if (is_digit) begin
                case (key_reg)
                    KEY_W: begin
                        wacc_next = (w_mul > {4'b0000, ACC_CAP}) ? ACC_CAP
                                                                 : w_mul[ACC_BITS-1:0];
                    end
                    KEY_H: begin
                        hacc_next = (h_mul > {4'b0000, ACC_CAP}) ? ACC_CAP
                                                                 : h_mul[ACC_BITS-1:0];
                    end
                    KEY_C: begin
                        crop_next = digit;
                    end
                    KEY_Q: begin
                        qacc_next = (q_mul > {4'b0000, QACC_CAP}) ? QACC_CAP
                                                                  : q_mul[QACC_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end else if (char_byte == CH_AMP || char_byte == CH_EQ) begin
                phase_next = PH_PARAMS;
            end else begin
                phase_next = PH_ERROR;
            end
        end
    end

    // result seen on the final byte
    always_comb begin
        result.width   = '0;
        result.height  = '0;
        result.crop    = DEFAULT_CROP;
        result.quality = DEFAULT_QUALITY;
        if (NAME_LEN_BITS >= NAME_OUT_BITS) begin
            result.name_length = name_next[NAME_OUT_BITS-1:0];
        end else begin
            result.name_length = NAME_OUT_BITS'(name_next);
        end
        if (phase_next == PH_NAME) begin
            result.status = ST_NO_QUERY;
        end else if (phase_next == PH_ERROR) begin
            result.status = ST_SYNTAX;
        end else if (wacc_next > ACC_BITS'(max_width) ||
                     hacc_next > ACC_BITS'(max_height)) begin
            result.status = ST_SIZE_OOR;
        end else begin
            result.status = ST_OK;
            result.width  = wacc_next[SIZE_BITS-1:0];
            result.height = hacc_next[SIZE_BITS-1:0];
            result.crop   = crop_next;
            if (qacc_next != '0 && qacc_next < QACC_BITS'(DEFAULT_QUALITY)) begin
                result.quality = qacc_next[QUAL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (proc_en && last_byte)) begin
            phase_reg <= PH_NAME;
            key_reg   <= KEY_NONE;
            wacc_reg  <= '0;
            hacc_reg  <= '0;
            crop_reg  <= DEFAULT_CROP;
            qacc_reg  <= '0;
            name_reg  <= '0;
        end else if (proc_en) begin
            phase_reg <= phase_next;
            key_reg   <= key_next;
            wacc_reg  <= wacc_next;
            hacc_reg  <= hacc_next;
            crop_reg  <= crop_next;
            qacc_reg  <= qacc_next;
            name_reg  <= name_next;
        end
    end

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_en && last_byte) |=> (phase_reg == PH_NAME && name_reg == '0))
        else $error("parse state not cleared after final beat");

    a_name_phase_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_NAME) |-> (wacc_reg == '0 && hacc_reg == '0 &&
                                    qacc_reg == '0 && key_reg == KEY_NONE))
        else $error("accumulators touched during name scan");

    a_crop_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        crop_reg <= CROP_BITS'(9))
        else $error("crop holds a non-digit value");

endmodule

`default_nettype wire

// ===== hw/rtl/uri_query_param_parser.sv =====
// Top level of the URI query parameter parser: input beat register,
// limit registers, parse core and result register. Depends on uqp_pkg, uqp_core.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  tdata = char_byte, tlast = last_byte
//  m_        out  m_tvalid/m_tready  tdata = status,width,height,crop,quality,name_length
//  cfg_      in   cfg_we             cfg_idx, cfg_wdata
//
// One byte per cycle unless m_ stalls; the result of a final byte is registered onto m_.
// The parse state update (one multiply-by-ten add per accumulator) sets the cycle.
// aresetn is synchronous; limits return to 4096 and the parse state is cleared.
// A stalled result holds the input register, which once full holds s_tready low.
`default_nettype none

module uri_query_param_parser #(
    parameter int ACC_BITS      = 20,
    parameter int NAME_LEN_BITS = 12
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output      logic                                 s_tready,
    input  wire logic [uqp_pkg::CHAR_BITS-1:0]        s_tdata,  // [7:0] char_byte
    input  wire logic                                 s_tlast,  // last_byte
    output      logic                                 m_tvalid,
    input  wire logic                                 m_tready,
    // [1:0] status, [17:2] width, [33:18] height, [37:34] crop,
    // [44:38] quality, [56:45] name_length, [63:57] zero
    output      logic [uqp_pkg::M_TDATA_BITS-1:0]     m_tdata,
    input  wire logic                                 cfg_we,
    input  wire logic [uqp_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
    input  wire logic [uqp_pkg::SIZE_BITS-1:0]        cfg_wdata
);
    import uqp_pkg::*;

    logic [SIZE_BITS-1:0] max_w_reg, max_h_reg;
    logic                 in_valid_reg;
    logic [CHAR_BITS-1:0] in_char_reg;
    logic                 in_last_reg;
    logic                 out_valid_reg;
    uqp_result_t          out_data_reg;
    uqp_result_t          core_result;
    logic                 out_free, proc_en;

    assign out_free = !out_valid_reg || m_tready;
    assign proc_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || proc_en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_BITS - $bits(uqp_result_t)){1'b0}}, out_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_w_reg <= MAX_SIZE_RESET;
            max_h_reg <= MAX_SIZE_RESET;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_MAX_WIDTH:  max_w_reg <= cfg_wdata;
                REG_MAX_HEIGHT: max_h_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    uqp_core #(
        .ACC_BITS      (ACC_BITS),
        .NAME_LEN_BITS (NAME_LEN_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .proc_en    (proc_en),
        .char_byte  (in_char_reg),
        .last_byte  (in_last_reg),
        .max_width  (max_w_reg),
        .max_height (max_h_reg),
        .result     (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= proc_en && in_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_en && in_last_reg) begin
            out_data_reg <= core_result;
        end
    end

endmodule

`default_nettype wire
